[src/r2b_pkg.sv]
// ============================================================================
// r2b_pkg - shared types and constants for the RGB565 to BMP24 stream core
// Command format between front and back, header layout, byte step codes.
// ============================================================================
`default_nettype none

package r2b_pkg;

    // largest image side accepted by default
    localparam int unsigned MAX_DIMENSION_DEF = 4096;

    // configuration register width (fixed by the register map)
    localparam int unsigned CFG_W = 13;

    // command queue between front and back
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = 2;

    // byte step within one pixel's run: header bytes, then B, G, R, then pad
    localparam int unsigned STEP_W   = 6;
    localparam logic [STEP_W-1:0] HDR_LEN = 6'd54;
    localparam logic [STEP_W-1:0] STEP_B  = 6'd54;
    localparam logic [STEP_W-1:0] STEP_G  = 6'd55;
    localparam logic [STEP_W-1:0] STEP_R  = 6'd56;

    // header content
    localparam logic [STEP_W-1:0] OFS_SIG_B   = 6'd0;
    localparam logic [STEP_W-1:0] OFS_SIG_M   = 6'd1;
    localparam logic [STEP_W-1:0] OFS_WORDS   = 6'd2;
    localparam logic [7:0]        CHAR_B      = 8'h42;
    localparam logic [7:0]        CHAR_M      = 8'h4D;
    localparam logic [31:0]       DATA_OFFSET = 32'd54;
    localparam logic [31:0]       INFO_SIZE   = 32'd40;
    localparam logic [15:0]       PLANES      = 16'd1;
    localparam logic [15:0]       BPP         = 16'd24;

    // 32-bit header words, counted from byte offset 2
    localparam logic [3:0] WORD_TOTAL_LEN = 4'd0;
    localparam logic [3:0] WORD_DATA_OFS  = 4'd2;
    localparam logic [3:0] WORD_INFO_SIZE = 4'd3;
    localparam logic [3:0] WORD_WIDTH     = 4'd4;
    localparam logic [3:0] WORD_HEIGHT    = 4'd5;
    localparam logic [3:0] WORD_PLANES    = 4'd6;
    localparam logic [3:0] WORD_PIXEL_LEN = 4'd8;

    // one queued pixel with its classification
    typedef struct packed {
        logic [15:0] pixel;
        logic        header;     // header goes out ahead of this pixel
        logic [1:0]  pad;        // zero bytes after this pixel
        logic        frame_end;  // last pixel of the frame
    } t_cmd;

    // header values, all little-endian 32-bit words
    typedef struct packed {
        logic [31:0] total_len;
        logic [31:0] pixel_len;
        logic [31:0] width;
        logic [31:0] height;
    } t_hdr_info;

    function automatic logic [7:0] hdr_byte(input logic [STEP_W-1:0] step,
                                            input t_hdr_info info);
        logic [STEP_W-1:0] rel;
        logic [31:0]       word;
        logic [7:0]        res;
        rel  = step - OFS_WORDS;
        word = '0;
        unique case (rel[STEP_W-1:2])
            WORD_TOTAL_LEN: word = info.total_len;
            WORD_DATA_OFS:  word = DATA_OFFSET;
            WORD_INFO_SIZE: word = INFO_SIZE;
            WORD_WIDTH:     word = info.width;
            WORD_HEIGHT:    word = info.height;
            WORD_PLANES:    word = {BPP, PLANES};
            WORD_PIXEL_LEN: word = info.pixel_len;
            default:        word = '0;
        endcase
        res = 8'(word >> {rel[1:0], 3'b000});
        if (step == OFS_SIG_B) begin
            res = CHAR_B;
        end else if (step == OFS_SIG_M) begin
            res = CHAR_M;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[src/rgb565_to_bmp24_stream_core.sv]
// ============================================================================
// rgb565_to_bmp24_stream_core - RGB565 pixels in, 24-bit BMP byte stream out
// Front classifies pixels, a 4-entry queue decouples it from the byte back end.
// ============================================================================
//
//  channel   | direction | handshake                    | payload
//  ----------+-----------+------------------------------+---------------------------------
//  pixel in  | in        | push / full                  | i_pixel[15:0]
//  bytes out | out       | pop / empty                  | o_out_byte, o_last_of_run,
//            |           |                              | o_frame_end
//  config    | in        | psel, penable, pwrite, pready| paddr[2:0], pwdata, prdata
//
//  Bytes: each pixel makes 3 output bytes (B, G, R), plus 0..3 pad bytes at
//  a row end and 54 header bytes ahead of the first pixel of a frame. The
//  byte-wide output register sets the rate: one byte per cycle while pop holds.
//  Path: an accepted pixel passes the command queue and the back end's command
//  register before its first byte reaches the output register.
//  Stalls: the input only stalls when the 4-entry command queue is full; a
//  stalled output (pop low) holds the output register and the back end.
//  Reset: synchronous, active low; clears counters, queue and output valid,
//  sets both dimensions to 1 and arms the header for the next pixel.
//
`default_nettype none

module rgb565_to_bmp24_stream_core import r2b_pkg::*; #(
    parameter int unsigned MAX_DIMENSION = MAX_DIMENSION_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // pixel input
    input  wire logic        push,
    output      logic        full,
    input  wire logic [15:0] i_pixel,
    // byte output
    output      logic        empty,
    input  wire logic        pop,
    output      logic [7:0]  o_out_byte,
    output      logic        o_last_of_run,
    output      logic        o_frame_end,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output      logic [31:0] prdata,
    output      logic        pready
);

    // effective dimension width and padded row length width
    localparam int unsigned DIM_W = $clog2(MAX_DIMENSION + 1);
    localparam int unsigned RB_W  = $clog2(3 * MAX_DIMENSION + 4);

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    logic [CFG_W-1:0]      r_image_width;
    logic [CFG_W-1:0]      r_image_height;
    logic                  w_cfg_wr;
    logic [DIM_W-1:0]      w_eff_w;
    logic [DIM_W-1:0]      w_eff_h;
    logic [RB_W-1:0]       w_row_sum;
    logic [RB_W-1:0]       r_row_bytes;
    logic [RB_W+DIM_W-1:0] w_prod;
    logic [31:0]           r_pixel_len;
    logic [31:0]           r_total_len;
    t_hdr_info             w_hdr;
    t_cmd                  w_wr_cmd;
    t_cmd                  w_rd_cmd;
    logic                  w_wr;
    logic                  w_rd;
    logic                  w_q_empty;

    // ---------------- configuration port ----------------
    // two registers, decoded on paddr[2]; pready is tied high
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= CFG_W'(1);
            r_image_height <= CFG_W'(1);
        end else if (w_cfg_wr) begin
            unique case (paddr[2])
                REG_WIDTH:  r_image_width  <= pwdata[CFG_W-1:0];
                REG_HEIGHT: r_image_height <= pwdata[CFG_W-1:0];
                default:    r_image_width  <= r_image_width;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_WIDTH:  prdata = 32'(r_image_width);
            REG_HEIGHT: prdata = 32'(r_image_height);
            default:    prdata = '0;
        endcase
    end

    // ---------------- effective dimensions ----------------
    // zero acts as 1, anything above the maximum acts as the maximum
    always_comb begin
        if (r_image_width == '0) begin
            w_eff_w = DIM_W'(1);
        end else if (32'(r_image_width) > 32'(MAX_DIMENSION)) begin
            w_eff_w = DIM_W'(MAX_DIMENSION);
        end else begin
            w_eff_w = DIM_W'(r_image_width);
        end
        if (r_image_height == '0) begin
            w_eff_h = DIM_W'(1);
        end else if (32'(r_image_height) > 32'(MAX_DIMENSION)) begin
            w_eff_h = DIM_W'(MAX_DIMENSION);
        end else begin
            w_eff_h = DIM_W'(r_image_height);
        end
    end

    // ---------------- header sizes ----------------
    // padded row = (3w + 3) & ~3; pixel array = row * h; file = pixel array + 54.
    // Three register stages; they settle well before header byte 2 goes out.
    assign w_row_sum = (RB_W'(w_eff_w) << 1) + RB_W'(w_eff_w) + RB_W'(3);
    assign w_prod    = {{DIM_W{1'b0}}, r_row_bytes} * {{RB_W{1'b0}}, w_eff_h};

    always_ff @(posedge i_clk) begin
        r_row_bytes <= {w_row_sum[RB_W-1:2], 2'b00};
        r_pixel_len <= 32'(w_prod);
        r_total_len <= r_pixel_len + DATA_OFFSET;
    end

    always_comb begin
        w_hdr.total_len = r_total_len;
        w_hdr.pixel_len = r_pixel_len;
        w_hdr.width     = 32'(w_eff_w);
        w_hdr.height    = 32'(w_eff_h);
    end

    // ---------------- front: accept and classify ----------------
    r2b_front #(
        .DIM_W (DIM_W)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pixel (i_pixel),
        .i_full  (full),
        .i_eff_w (w_eff_w),
        .i_eff_h (w_eff_h),
        .o_wr    (w_wr),
        .o_cmd   (w_wr_cmd)
    );

    // ---------------- command queue ----------------
    r2b_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wr),
        .i_wdata (w_wr_cmd),
        .i_rd    (w_rd),
        .o_rdata (w_rd_cmd),
        .o_full  (full),
        .o_empty (w_q_empty)
    );

    // ---------------- back: byte sequencer ----------------
    r2b_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_rd_cmd),
        .i_cmd_empty   (w_q_empty),
        .o_cmd_rd      (w_rd),
        .i_hdr         (w_hdr),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run),
        .o_frame_end   (o_frame_end)
    );

endmodule

`default_nettype wire

[src/r2b_front.sv]
// ============================================================================
// r2b_front - pixel intake and row/frame classification
// Tracks column and row, flags header, row padding and frame end per pixel.
// ============================================================================
`default_nettype none

module r2b_front import r2b_pkg::*; #(
    parameter int unsigned DIM_W = 13
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [15:0]      i_pixel,
    input  wire logic             i_full,
    input  wire logic [DIM_W-1:0] i_eff_w,
    input  wire logic [DIM_W-1:0] i_eff_h,
    output      logic             o_wr,
    output      t_cmd             o_cmd
);

    logic [DIM_W-1:0] r_col, n_col;
    logic [DIM_W-1:0] r_row, n_row;
    logic             r_header_pending, n_header_pending;
    logic [DIM_W:0]   w_col_inc;
    logic [DIM_W:0]   w_row_inc;
    logic             w_row_end;
    logic             w_frame_end;

    assign o_wr      = i_push && !i_full;
    assign w_col_inc = {1'b0, r_col} + (DIM_W+1)'(1);
    assign w_row_inc = {1'b0, r_row} + (DIM_W+1)'(1);
    assign w_row_end   = (w_col_inc >= {1'b0, i_eff_w});
    assign w_frame_end = w_row_end && (w_row_inc >= {1'b0, i_eff_h});

    always_comb begin
        o_cmd.pixel     = i_pixel;
        o_cmd.header    = r_header_pending;
        o_cmd.pad       = w_row_end ? i_eff_w[1:0] : 2'b00;  // (4 - 3w mod 4) mod 4
        o_cmd.frame_end = w_frame_end;
    end

    always_comb begin
        n_col            = r_col;
        n_row            = r_row;
        n_header_pending = r_header_pending;
        if (o_wr) begin
            n_header_pending = w_frame_end;
            if (!w_row_end) begin
                n_col = w_col_inc[DIM_W-1:0];
            end else begin
                n_col = '0;
                n_row = w_frame_end ? '0 : w_row_inc[DIM_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col            <= '0;
            r_row            <= '0;
            r_header_pending <= 1'b1;
        end else begin
            r_col            <= n_col;
            r_row            <= n_row;
            r_header_pending <= n_header_pending;
        end
    end

endmodule

`default_nettype wire

[src/r2b_fifo.sv]
// ============================================================================
// r2b_fifo - short command queue between front and back
// Register-based FIFO of classified pixels.
// ============================================================================
`default_nettype none

module r2b_fifo import r2b_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_wr,
    input  wire t_cmd i_wdata,
    input  wire logic i_rd,
    output      t_cmd o_rdata,
    output      logic o_full,
    output      logic o_empty
);

    t_cmd               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_AW:0]   r_count;

    assign o_full  = (r_count == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(1);
            end
            if (i_rd) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            unique case ({i_wr, i_rd})
                2'b10:   r_count <= r_count + (FIFO_AW+1)'(1);
                2'b01:   r_count <= r_count - (FIFO_AW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

[src/r2b_back.sv]
// ============================================================================
// r2b_back - byte sequencer and output register
// Expands each command into header, B/G/R and pad bytes, one per cycle unless stalled.
// ============================================================================
`default_nettype none

module r2b_back import r2b_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cmd      i_cmd,
    input  wire logic      i_cmd_empty,
    output      logic      o_cmd_rd,
    input  wire t_hdr_info i_hdr,
    input  wire logic      i_pop,
    output      logic      o_empty,
    output      logic [7:0] o_out_byte,
    output      logic      o_last_of_run,
    output      logic      o_frame_end
);

    t_cmd              r_cur;
    logic              r_busy;
    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] r_last;
    logic              r_out_valid;
    logic [7:0]        r_out_byte;
    logic              r_out_last;
    logic              r_out_fend;
    logic              w_adv;
    logic              w_emit;
    logic              w_at_last;
    logic [7:0]        w_byte;

    assign w_adv     = !r_out_valid || i_pop;
    assign w_emit    = r_busy && w_adv;
    assign w_at_last = (r_step == r_last);
    assign o_cmd_rd  = !i_cmd_empty && (!r_busy || (w_emit && w_at_last));

    always_comb begin
        priority if (r_step < HDR_LEN) begin
            w_byte = hdr_byte(r_step, i_hdr);
        end else if (r_step == STEP_B) begin
            w_byte = {r_cur.pixel[4:0], 3'b000};
        end else if (r_step == STEP_G) begin
            w_byte = {r_cur.pixel[10:5], 2'b00};
        end else if (r_step == STEP_R) begin
            w_byte = {r_cur.pixel[15:11], 3'b000};
        end else begin
            w_byte = 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_rd) begin
            r_cur  <= i_cmd;
            r_last <= STEP_R + STEP_W'(i_cmd.pad);
        end
        if (o_cmd_rd) begin
            r_step <= i_cmd.header ? '0 : STEP_B;
        end else if (w_emit) begin
            r_step <= r_step + STEP_W'(1);
        end
        if (w_emit) begin
            r_out_byte <= w_byte;
            r_out_last <= w_at_last;
            r_out_fend <= w_at_last && r_cur.frame_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd_rd) begin
                r_busy <= 1'b1;
            end else if (w_emit && w_at_last) begin
                r_busy <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= w_emit;
            end
        end
    end

    assign o_empty       = !r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_last_of_run = r_out_last;
    assign o_frame_end   = r_out_fend;

endmodule

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 100ps
// ============================================================================
// tb - self-checking bench for rgb565_to_bmp24_stream_core
// A byte-level encoder model tracks the BMP header, the pixel bytes, the row
// padding and the frame boundaries. It predicts every byte the core must
// emit. A queue-fed driver and a checking monitor run with random gaps on
// both sides. Registers are written between phases, including mid-frame.
// ============================================================================

module tb import r2b_pkg::*;;

    // register indexes, byte address is index * 4
    localparam int REG_IMAGE_WIDTH  = 0;
    localparam int REG_IMAGE_HEIGHT = 1;

    // stimulus size and length of the long receiver hold
    localparam int RANDOM_TARGET = 310;
    localparam int LONG_HOLD     = 300;

    // one predicted output byte with its flags
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       fend;
    } t_bmp_byte;

    // ------------------------------------------------------------------------
    // clock and DUT ports, all inputs known from time zero
    // ------------------------------------------------------------------------
    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push    = 1'b0;
    logic [15:0] i_pixel = '0;
    logic        pop     = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic        full;
    logic        empty;
    logic [7:0]  o_out_byte;
    logic        o_last_of_run;
    logic        o_frame_end;
    logic [31:0] prdata;
    logic        pready;

    rgb565_to_bmp24_stream_core DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_pixel      (i_pixel),
        .empty        (empty),
        .pop          (pop),
        .o_out_byte   (o_out_byte),
        .o_last_of_run(o_last_of_run),
        .o_frame_end  (o_frame_end),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // encoder model: register copies, counters, and the bytes still due
    // ------------------------------------------------------------------------
    logic [12:0]  width_cfg  = 13'd1;
    logic [12:0]  height_cfg = 13'd1;
    int unsigned  col_cnt    = 0;
    int unsigned  row_cnt    = 0;
    bit           hdr_due    = 1'b1;
    t_bmp_byte    bmp_bytes_due[$];

    logic [15:0]  pixels_to_send[$];
    int           pixels_queued = 0;
    int           error_count   = 0;

    // idling controls; steady turns off all gaps on both sides
    bit           steady        = 1'b0;
    int           hold_requests = 0;
    int           holds_served  = 0;

    // register value 0 acts as 1, anything above the max clamps
    function automatic int unsigned eff_dim(input logic [12:0] v);
        if (v == 0) return 1;
        if (v > MAX_DIMENSION_DEF) return MAX_DIMENSION_DEF;
        return v;
    endfunction

    // zero bytes needed to round a row of w pixels up to 4 bytes
    function automatic int unsigned row_pad(input int unsigned w);
        return (4 - ((w * 3) & 3)) & 3;
    endfunction

    function automatic void put_byte(input logic [7:0] b);
        t_bmp_byte nb;
        nb.data = b;
        nb.last = 1'b0;
        nb.fend = 1'b0;
        bmp_bytes_due.push_back(nb);
    endfunction

    function automatic void put_word(input logic [31:0] w);
        for (int k = 0; k < 4; k++) put_byte(w[8*k +: 8]);
    endfunction

    // everything one accepted pixel makes the core emit
    function automatic void encode_pixel(input logic [15:0] px);
        int unsigned w;
        int unsigned h;
        logic [31:0] img_bytes;
        bit          frame_done;
        t_bmp_byte   tail;
        w          = eff_dim(width_cfg);
        h          = eff_dim(height_cfg);
        frame_done = 1'b0;

        if (hdr_due) begin
            img_bytes = 32'((w * 3 + row_pad(w)) * h);
            put_byte(8'h42);                // 'B'
            put_byte(8'h4D);                // 'M'
            put_word(32'd54 + img_bytes);   // whole file length
            put_word(32'd0);                // reserved
            put_word(32'd54);               // pixel data offset
            put_word(32'd40);               // info header size
            put_word(32'(w));
            put_word(32'(h));
            put_byte(8'd1);                 // planes
            put_byte(8'd0);
            put_byte(8'd24);                // bits per pixel
            put_byte(8'd0);
            put_word(32'd0);                // no compression
            put_word(img_bytes);
            for (int k = 0; k < 16; k++) put_byte(8'd0);
            hdr_due = 1'b0;
        end

        // B, G, R with the low bits left at zero
        put_byte({px[4:0], 3'b000});
        put_byte({px[10:5], 2'b00});
        put_byte({px[15:11], 3'b000});

        // row and frame end use >=, so a shrunk register ends them at once
        col_cnt++;
        if (col_cnt >= w) begin
            for (int k = 0; k < row_pad(w); k++) put_byte(8'd0);
            col_cnt = 0;
            row_cnt++;
            if (row_cnt >= h) begin
                row_cnt    = 0;
                hdr_due    = 1'b1;
                frame_done = 1'b1;
            end
        end

        tail      = bmp_bytes_due.pop_back();
        tail.last = 1'b1;
        tail.fend = frame_done;
        bmp_bytes_due.push_back(tail);
    endfunction

    // mostly back to back, sometimes short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [15:0] rand_pixel();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 16'h0000;
        if (r == 1) return 16'hFFFF;
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic void queue_pixel(input logic [15:0] px);
        pixels_to_send.push_back(px);
        pixels_queued++;
    endfunction

    // ------------------------------------------------------------------------
    // pixel driver: holds push until the transfer, then takes the next item
    // ------------------------------------------------------------------------
    int tx_gap = 0;
    bit tx_took;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push   <= 1'b0;
            tx_gap <= 0;
        end else begin
            tx_took = push && !full;
            if (tx_took) encode_pixel(i_pixel);
            if (push && !tx_took) begin
                // stalled by full: keep offering the same pixel
            end else if (tx_gap > 0) begin
                tx_gap <= tx_gap - 1;
                push   <= 1'b0;
            end else if (pixels_to_send.size() > 0) begin
                push    <= 1'b1;
                i_pixel <= pixels_to_send.pop_front();
                tx_gap  <= pick_gap();
            end else begin
                push <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // byte monitor: checks each transfer against the oldest predicted byte
    // ------------------------------------------------------------------------
    int        rx_gap   = 0;
    int        rx_hold  = 0;
    t_bmp_byte want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (bmp_bytes_due.size() == 0) begin
                    $display("%0t: byte 0x%02h with none predicted", $time, o_out_byte);
                    error_count++;
                end else begin
                    want = bmp_bytes_due.pop_front();
                    if (o_out_byte !== want.data) begin
                        $display("%0t: out_byte expected 0x%02h got 0x%02h",
                                 $time, want.data, o_out_byte);
                        error_count++;
                    end
                    if (o_last_of_run !== want.last) begin
                        $display("%0t: last_of_run expected %0b got %0b",
                                 $time, want.last, o_last_of_run);
                        error_count++;
                    end
                    if (o_frame_end !== want.fend) begin
                        $display("%0t: frame_end expected %0b got %0b",
                                 $time, want.fend, o_frame_end);
                        error_count++;
                    end
                end
            end

            // long hold-off on request, so the core backs up and raises full
            if (holds_served < hold_requests) begin
                holds_served++;
                rx_hold = LONG_HOLD;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                pop <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                pop <= 1'b0;
            end else begin
                pop    <= 1'b1;
                rx_gap = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------------
    // register access, only when nothing is queued, in flight or still due
    // ------------------------------------------------------------------------
    // sampled mid-cycle, after the driver's updates of the last edge settled
    task automatic wait_drained();
        @(negedge i_clk);
        while (pixels_to_send.size() != 0 || push || bmp_bytes_due.size() != 0)
            @(negedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // write one register (junk in the unused upper bits), then read it back
    task automatic write_reg(input int idx, input logic [12:0] value);
        logic [31:0] word;
        word       = $urandom;
        word[12:0] = value;
        wait_drained();
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(idx * 4);
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (idx == REG_IMAGE_WIDTH) width_cfg = value;
        else height_cfg = value;
        // straight into the read setup cycle
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== {19'b0, value}) begin
            $display("%0t: reg %0d read expected 0x%08h got 0x%08h",
                     $time, idx, {19'b0, value}, prdata);
            error_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial begin
        int w;
        int h;
        int n;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset dimensions 1x1: every pixel is a whole file, pad of one byte
        queue_pixel(16'h0000);
        queue_pixel(16'hFFFF);
        queue_pixel(16'hF800);
        queue_pixel(16'h07E0);
        queue_pixel(16'h001F);

        // zero registers act as 1
        write_reg(REG_IMAGE_WIDTH, 13'd0);
        write_reg(REG_IMAGE_HEIGHT, 13'd0);
        queue_pixel(16'hAAAA);
        queue_pixel(16'h5555);

        // 3 wide: 9 bytes per row, 3 pad bytes
        write_reg(REG_IMAGE_WIDTH, 13'd3);
        write_reg(REG_IMAGE_HEIGHT, 13'd2);
        for (int k = 0; k < 6; k++) queue_pixel(rand_pixel());

        // 2 wide, pad of two
        write_reg(REG_IMAGE_WIDTH, 13'd2);
        write_reg(REG_IMAGE_HEIGHT, 13'd1);
        queue_pixel(16'h8421);
        queue_pixel(16'h7BDE);

        // 4 wide, no padding
        write_reg(REG_IMAGE_WIDTH, 13'd4);
        for (int k = 0; k < 4; k++) queue_pixel(rand_pixel());

        // oversize registers clamp; then shrink both mid-frame to end it early
        write_reg(REG_IMAGE_WIDTH, 13'h1FFF);
        write_reg(REG_IMAGE_HEIGHT, 13'h1FFF);
        queue_pixel(rand_pixel());
        queue_pixel(rand_pixel());
        write_reg(REG_IMAGE_WIDTH, 13'd1);
        queue_pixel(rand_pixel());
        write_reg(REG_IMAGE_HEIGHT, 13'd0);
        queue_pixel(rand_pixel());

        // just above and exactly at the max side
        write_reg(REG_IMAGE_WIDTH, 13'd4097);
        write_reg(REG_IMAGE_HEIGHT, 13'd4096);
        queue_pixel(rand_pixel());
        write_reg(REG_IMAGE_WIDTH, 13'd1);
        write_reg(REG_IMAGE_HEIGHT, 13'd1);
        queue_pixel(rand_pixel());

        // back-pressure: receiver stops while the sender keeps pushing
        write_reg(REG_IMAGE_WIDTH, 13'd5);
        write_reg(REG_IMAGE_HEIGHT, 13'd4);
        steady = 1'b1;
        hold_requests++;
        for (int k = 0; k < 30; k++) queue_pixel(rand_pixel());

        // random frames, mostly whole ones, some cut short
        while (pixels_queued < RANDOM_TARGET) begin
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
            h = $urandom_range(1, 3);
            n = w * h * $urandom_range(1, 2);
            if ($urandom_range(0, 4) == 0) n = $urandom_range(1, n);
            write_reg(REG_IMAGE_WIDTH, 13'(w));
            write_reg(REG_IMAGE_HEIGHT, 13'(h));
            steady = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < n; k++) queue_pixel(rand_pixel());
        end

        // drain, then give stray bytes a chance to show up
        wait_drained();
        repeat (40) @(posedge i_clk);
        if (error_count == 0) begin
            $display("rgb565_to_bmp24_stream_core: match");
        end else begin
            $display("rgb565_to_bmp24_stream_core: mismatch");
        end
        $finish;
    end

    // run guard, far above the slowest legal run
    initial begin
        #20_000_000;
        $display("rgb565_to_bmp24_stream_core: mismatch");
        $finish;
    end

endmodule
